// ===== design/spi_pkg.sv =====
package spi_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int OUT_BITS    = 24;

   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int NUMER_BITS  = DIFF_BITS + CROSS_BITS + 1;
   localparam int SCALED_BITS = NUMER_BITS + FRAC_BITS;
   localparam int REM_BITS    = (SCALED_BITS > CROSS_BITS + OUT_BITS) ?
                                SCALED_BITS : CROSS_BITS + OUT_BITS;

   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } spi_segs_type;

   typedef struct packed {
      logic touches;
      logic point_valid;
   } spi_geom_flags_type;

   typedef struct packed {
      logic touches;
      logic point_valid;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } spi_side_type;

   typedef struct packed {
      logic                       touches;
      logic                       point_valid;
      logic signed [OUT_BITS-1:0] cross_x;
      logic signed [OUT_BITS-1:0] cross_y;
   } spi_result_type;

endpackage

// ===== design/spi_ifs.sv =====
interface spi_req_if import spi_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type first_start_x;
   coord_type first_start_y;
   coord_type first_end_x;
   coord_type first_end_y;
   coord_type second_start_x;
   coord_type second_start_y;
   coord_type second_end_x;
   coord_type second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );
   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

interface spi_rsp_if import spi_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       touches;
   logic                       point_valid;
   logic signed [OUT_BITS-1:0] cross_x;
   logic signed [OUT_BITS-1:0] cross_y;

   modport source (
      output valid, touches, point_valid, cross_x, cross_y,
      input  ready
   );
   modport sink (
      input  valid, touches, point_valid, cross_x, cross_y,
      output ready
   );
endinterface

// ===== design/spi_geom.sv =====
module spi_geom import spi_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  spi_segs_type                  in_segs,
   output logic                          out_valid,
   output spi_geom_flags_type            out_flags,
   output logic signed [SCALED_BITS-1:0] out_num_x,
   output logic signed [SCALED_BITS-1:0] out_num_y,
   output logic signed [CROSS_BITS-1:0]  out_den
);

   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   function automatic logic between(coord_type l, coord_type m, coord_type r);
      between = (m >= l && m <= r) || (m >= r && m <= l);
   endfunction

   function automatic diff_type dif(coord_type a, coord_type b);
      dif = DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

   function automatic prod_type mul(diff_type a, diff_type b);
      mul = PROD_BITS'(a) * PROD_BITS'(b);
   endfunction

   function automatic cross_type sub(prod_type a, prod_type b);
      sub = CROSS_BITS'(a) - CROSS_BITS'(b);
   endfunction

   logic [5:1] valid_ff;

   // stage 1: coordinates and differences
   coord_type px_ff, py_ff, qx_ff, qy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   diff_type  rx_ff, ry_ff, sx_ff, sy_ff, apx_ff, apy_ff;
   diff_type  d1x_ff, d1y_ff, d2x_ff, d2y_ff, d3x_ff, d3y_ff, d4x_ff, d4y_ff;

   // stage 2: products and box checks
   prod_type  o1a_ff, o1b_ff, o2a_ff, o2b_ff, o3a_ff, o3b_ff, o4a_ff, o4b_ff;
   prod_type  dna_ff, dnb_ff, nma_ff, nmb_ff;
   coord_type px2_ff, py2_ff;
   diff_type  rx2_ff, ry2_ff;
   logic [3:0] box2_ff;

   // stage 3: cross products
   cross_type c1_ff, c2_ff, c3_ff, c4_ff, den3_ff, num3_ff;
   coord_type px3_ff, py3_ff;
   diff_type  rx3_ff, ry3_ff;
   logic [3:0] box3_ff;

   // stage 4: decision and numerator products
   spi_geom_flags_type flags4_ff;
   logic signed [COORD_BITS+CROSS_BITS-1:0] pxd_ff, pyd_ff;
   logic signed [DIFF_BITS+CROSS_BITS-1:0]  rxn_ff, ryn_ff;
   cross_type den4_ff;

   // stage 5: scaled numerators
   spi_geom_flags_type flags5_ff;
   logic signed [SCALED_BITS-1:0] nx5_ff, ny5_ff;
   cross_type den5_ff;

   logic [3:0] z_in, n_in;
   logic       hit_in;
   logic signed [NUMER_BITS-1:0] nx_in, ny_in;

   always_comb begin
      z_in   = {c4_ff == '0, c3_ff == '0, c2_ff == '0, c1_ff == '0};
      n_in   = {c4_ff[CROSS_BITS-1], c3_ff[CROSS_BITS-1],
                c2_ff[CROSS_BITS-1], c1_ff[CROSS_BITS-1]};
      hit_in = (({z_in[0], n_in[0]} != {z_in[1], n_in[1]}) &&
                ({z_in[2], n_in[2]} != {z_in[3], n_in[3]})) ||
               |(z_in & box3_ff);
      nx_in  = NUMER_BITS'(pxd_ff) + NUMER_BITS'(rxn_ff);
      ny_in  = NUMER_BITS'(pyd_ff) + NUMER_BITS'(ryn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff  <= in_segs.first_start_x;
         py_ff  <= in_segs.first_start_y;
         qx_ff  <= in_segs.first_end_x;
         qy_ff  <= in_segs.first_end_y;
         ax_ff  <= in_segs.second_start_x;
         ay_ff  <= in_segs.second_start_y;
         bx_ff  <= in_segs.second_end_x;
         by_ff  <= in_segs.second_end_y;
         rx_ff  <= dif(in_segs.first_end_x, in_segs.first_start_x);
         ry_ff  <= dif(in_segs.first_end_y, in_segs.first_start_y);
         sx_ff  <= dif(in_segs.second_end_x, in_segs.second_start_x);
         sy_ff  <= dif(in_segs.second_end_y, in_segs.second_start_y);
         apx_ff <= dif(in_segs.second_start_x, in_segs.first_start_x);
         apy_ff <= dif(in_segs.second_start_y, in_segs.first_start_y);
         d1x_ff <= dif(in_segs.second_start_x, in_segs.first_end_x);
         d1y_ff <= dif(in_segs.second_start_y, in_segs.first_end_y);
         d2x_ff <= dif(in_segs.second_end_x, in_segs.first_end_x);
         d2y_ff <= dif(in_segs.second_end_y, in_segs.first_end_y);
         d3x_ff <= dif(in_segs.first_start_x, in_segs.second_end_x);
         d3y_ff <= dif(in_segs.first_start_y, in_segs.second_end_y);
         d4x_ff <= dif(in_segs.first_end_x, in_segs.second_end_x);
         d4y_ff <= dif(in_segs.first_end_y, in_segs.second_end_y);

         o1a_ff  <= mul(ry_ff, d1x_ff);
         o1b_ff  <= mul(rx_ff, d1y_ff);
         o2a_ff  <= mul(ry_ff, d2x_ff);
         o2b_ff  <= mul(rx_ff, d2y_ff);
         o3a_ff  <= mul(sy_ff, d3x_ff);
         o3b_ff  <= mul(sx_ff, d3y_ff);
         o4a_ff  <= mul(sy_ff, d4x_ff);
         o4b_ff  <= mul(sx_ff, d4y_ff);
         dna_ff  <= mul(rx_ff, sy_ff);
         dnb_ff  <= mul(ry_ff, sx_ff);
         nma_ff  <= mul(apx_ff, sy_ff);
         nmb_ff  <= mul(apy_ff, sx_ff);
         px2_ff  <= px_ff;
         py2_ff  <= py_ff;
         rx2_ff  <= rx_ff;
         ry2_ff  <= ry_ff;
         box2_ff <= {between(ax_ff, qx_ff, bx_ff) && between(ay_ff, qy_ff, by_ff),
                     between(ax_ff, px_ff, bx_ff) && between(ay_ff, py_ff, by_ff),
                     between(px_ff, bx_ff, qx_ff) && between(py_ff, by_ff, qy_ff),
                     between(px_ff, ax_ff, qx_ff) && between(py_ff, ay_ff, qy_ff)};

         c1_ff   <= sub(o1a_ff, o1b_ff);
         c2_ff   <= sub(o2a_ff, o2b_ff);
         c3_ff   <= sub(o3a_ff, o3b_ff);
         c4_ff   <= sub(o4a_ff, o4b_ff);
         den3_ff <= sub(dna_ff, dnb_ff);
         num3_ff <= sub(nma_ff, nmb_ff);
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         rx3_ff  <= rx2_ff;
         ry3_ff  <= ry2_ff;
         box3_ff <= box2_ff;

         flags4_ff.touches     <= hit_in;
         flags4_ff.point_valid <= hit_in && (den3_ff != '0);
         pxd_ff  <= (COORD_BITS+CROSS_BITS)'(px3_ff) * (COORD_BITS+CROSS_BITS)'(den3_ff);
         pyd_ff  <= (COORD_BITS+CROSS_BITS)'(py3_ff) * (COORD_BITS+CROSS_BITS)'(den3_ff);
         rxn_ff  <= (DIFF_BITS+CROSS_BITS)'(rx3_ff) * (DIFF_BITS+CROSS_BITS)'(num3_ff);
         ryn_ff  <= (DIFF_BITS+CROSS_BITS)'(ry3_ff) * (DIFF_BITS+CROSS_BITS)'(num3_ff);
         den4_ff <= den3_ff;

         flags5_ff <= flags4_ff;
         nx5_ff    <= SCALED_BITS'(nx_in) <<< FRAC_BITS;
         ny5_ff    <= SCALED_BITS'(ny_in) <<< FRAC_BITS;
         den5_ff   <= den4_ff;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_flags = flags5_ff;
   assign out_num_x = nx5_ff;
   assign out_num_y = ny5_ff;
   assign out_den   = den5_ff;

endmodule

// ===== design/spi_div.sv =====
module spi_div import spi_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  spi_geom_flags_type            in_flags,
   input  logic signed [SCALED_BITS-1:0] in_num_x,
   input  logic signed [SCALED_BITS-1:0] in_num_y,
   input  logic signed [CROSS_BITS-1:0]  in_den,
   output logic                          out_valid,
   output spi_result_type                out_data
);

   function automatic logic [OUT_BITS-1:0] fmt(logic neg, logic ovf,
                                               logic [OUT_BITS-1:0] q);
      if (!neg) begin
         fmt = (ovf || q[OUT_BITS-1]) ? OUT_MAX : q;
      end else begin
         fmt = (ovf || (q[OUT_BITS-1] && q[OUT_BITS-2:0] != '0)) ? OUT_MIN : -q;
      end
   endfunction

   // magnitude stage
   logic                   valid_a_ff;
   spi_side_type           side_a_ff;
   logic [SCALED_BITS-1:0] nmag_x_ff, nmag_y_ff;
   logic [CROSS_BITS-1:0]  dmag_a_ff;

   // quotient stages, index 0 is the overflow check
   logic                   valid_ff [0:OUT_BITS];
   spi_side_type           side_ff  [0:OUT_BITS];
   logic [REM_BITS-1:0]    rem_x_ff [0:OUT_BITS];
   logic [REM_BITS-1:0]    rem_y_ff [0:OUT_BITS];
   logic [OUT_BITS-1:0]    q_x_ff   [0:OUT_BITS];
   logic [OUT_BITS-1:0]    q_y_ff   [0:OUT_BITS];
   logic [CROSS_BITS-1:0]  dmag_ff  [0:OUT_BITS];

   logic                   valid_o_ff;
   spi_result_type         data_o_ff;

   logic [REM_BITS-1:0]    dlim_in;
   spi_side_type           side0_in;

   always_comb begin
      dlim_in        = REM_BITS'(dmag_a_ff) << OUT_BITS;
      side0_in       = side_a_ff;
      side0_in.ovf_x = REM_BITS'(nmag_x_ff) >= dlim_in;
      side0_in.ovf_y = REM_BITS'(nmag_y_ff) >= dlim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff  <= 1'b0;
         valid_ff[0] <= 1'b0;
         valid_o_ff  <= 1'b0;
      end else if (advance) begin
         valid_a_ff  <= in_valid;
         valid_ff[0] <= valid_a_ff;
         valid_o_ff  <= valid_ff[OUT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_a_ff.touches     <= in_flags.touches;
         side_a_ff.point_valid <= in_flags.point_valid;
         side_a_ff.neg_x       <= in_num_x[SCALED_BITS-1] ^ in_den[CROSS_BITS-1];
         side_a_ff.neg_y       <= in_num_y[SCALED_BITS-1] ^ in_den[CROSS_BITS-1];
         side_a_ff.ovf_x       <= 1'b0;
         side_a_ff.ovf_y       <= 1'b0;
         nmag_x_ff <= in_num_x[SCALED_BITS-1] ? $unsigned(-in_num_x) : $unsigned(in_num_x);
         nmag_y_ff <= in_num_y[SCALED_BITS-1] ? $unsigned(-in_num_y) : $unsigned(in_num_y);
         dmag_a_ff <= in_den[CROSS_BITS-1] ? $unsigned(-in_den) : $unsigned(in_den);

         side_ff[0]  <= side0_in;
         rem_x_ff[0] <= REM_BITS'(nmag_x_ff);
         rem_y_ff[0] <= REM_BITS'(nmag_y_ff);
         q_x_ff[0]   <= '0;
         q_y_ff[0]   <= '0;
         dmag_ff[0]  <= dmag_a_ff;

         data_o_ff.touches     <= side_ff[OUT_BITS].touches;
         data_o_ff.point_valid <= side_ff[OUT_BITS].point_valid;
         data_o_ff.cross_x     <= side_ff[OUT_BITS].point_valid ?
            fmt(side_ff[OUT_BITS].neg_x, side_ff[OUT_BITS].ovf_x, q_x_ff[OUT_BITS]) : '0;
         data_o_ff.cross_y     <= side_ff[OUT_BITS].point_valid ?
            fmt(side_ff[OUT_BITS].neg_y, side_ff[OUT_BITS].ovf_y, q_y_ff[OUT_BITS]) : '0;
      end
   end

   for (genvar k = 0; k < OUT_BITS; k++) begin : g_step
      localparam int BIT = OUT_BITS - 1 - k;
      logic [REM_BITS-1:0] dsh;
      logic                ge_x, ge_y;
      logic [OUT_BITS-1:0] qx_in, qy_in;

      always_comb begin
         dsh        = REM_BITS'(dmag_ff[k]) << BIT;
         ge_x       = rem_x_ff[k] >= dsh;
         ge_y       = rem_y_ff[k] >= dsh;
         qx_in      = q_x_ff[k];
         qy_in      = q_y_ff[k];
         qx_in[BIT] = ge_x;
         qy_in[BIT] = ge_y;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[k+1]  <= side_ff[k];
            dmag_ff[k+1]  <= dmag_ff[k];
            rem_x_ff[k+1] <= ge_x ? rem_x_ff[k] - dsh : rem_x_ff[k];
            rem_y_ff[k+1] <= ge_y ? rem_y_ff[k] - dsh : rem_y_ff[k];
            q_x_ff[k+1]   <= qx_in;
            q_y_ff[k+1]   <= qy_in;
         end
      end
   end

   assign out_valid = valid_o_ff;
   assign out_data  = data_o_ff;

endmodule

// ===== design/spi_outbuf.sv =====
module spi_outbuf import spi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  spi_result_type in_data,
   output logic           in_ready,
   output logic           out_valid,
   output spi_result_type out_data,
   input  logic           out_ready
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   spi_result_type out_data_ff, skid_data_ff;
   logic           take, load_out, load_skid;

   always_comb begin
      take          = out_valid_ff && out_ready;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            load_out     = in_valid;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = in_valid;
         load_out     = in_valid;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         load_skid     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (load_out) begin
         out_data_ff <= in_data;
      end
      if (load_skid) begin
         skid_data_ff <= in_data;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (take && skid_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_valid)
      else $error("pipeline advanced into a full buffer");

endmodule

// ===== design/segment_pair_intersection_top.sv =====
// Segment pair intersection, fully pipelined.
// req_if carries one transaction per segment pair: the start and end points of
// two segments as signed 16-bit coordinates. rsp_if returns one transaction per
// request, in order: touches, point_valid and the crossing point cross_x and
// cross_y in signed fixed point with 8 fraction bits, truncated toward zero and
// saturated to 24 bits. The point is zero unless point_valid is set, which needs
// touching segments that are not parallel.
// Throughput: one transaction per cycle while the output buffer has room. The
// restoring divider resolves one quotient bit per pipeline stage, behind five
// geometry stages and two of sign and overflow handling.
// Reset (synchronous, active high) clears all valid bits; no transaction is in
// flight afterwards and req_if.ready is high.
// When rsp_if.ready is low, a two-entry output buffer takes one more result;
// once that entry is used, the whole pipeline holds and req_if.ready drops
// until the receiver takes a response.
module segment_pair_intersection_top import spi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   spi_req_if.sink   req_if,
   spi_rsp_if.source rsp_if
);

   logic                          advance;
   spi_segs_type                  segs;
   logic                          geom_valid;
   spi_geom_flags_type            geom_flags;
   logic signed [SCALED_BITS-1:0] geom_num_x, geom_num_y;
   logic signed [CROSS_BITS-1:0]  geom_den;
   logic                          div_valid;
   spi_result_type                div_data;
   spi_result_type                rsp_data;

   always_comb begin
      segs.first_start_x  = req_if.first_start_x;
      segs.first_start_y  = req_if.first_start_y;
      segs.first_end_x    = req_if.first_end_x;
      segs.first_end_y    = req_if.first_end_y;
      segs.second_start_x = req_if.second_start_x;
      segs.second_start_y = req_if.second_start_y;
      segs.second_end_x   = req_if.second_end_x;
      segs.second_end_y   = req_if.second_end_y;
   end

   assign req_if.ready = advance;

   spi_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_if.valid),
      .in_segs   (segs),
      .out_valid (geom_valid),
      .out_flags (geom_flags),
      .out_num_x (geom_num_x),
      .out_num_y (geom_num_y),
      .out_den   (geom_den)
   );

   spi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (geom_valid),
      .in_flags  (geom_flags),
      .in_num_x  (geom_num_x),
      .in_num_y  (geom_num_y),
      .in_den    (geom_den),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   spi_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid && advance),
      .in_data   (div_data),
      .in_ready  (advance),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.touches     = rsp_data.touches;
   assign rsp_if.point_valid = rsp_data.point_valid;
   assign rsp_if.cross_x     = rsp_data.cross_x;
   assign rsp_if.cross_y     = rsp_data.cross_y;

   a_point_needs_touch: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.point_valid) |-> rsp_if.touches)
      else $error("point reported for disjoint segments");

   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.point_valid) |-> (rsp_if.cross_x == '0 && rsp_if.cross_y == '0))
      else $error("crossing point nonzero without point_valid");

   a_hold_only_on_backlog: assert property (@(posedge clock) disable iff (reset)
      !advance |-> rsp_if.valid)
      else $error("pipeline held with no pending response");

endmodule
